// File: src/fre_pkg.sv
package fre_pkg;

	localparam int SET_COUNT = 16;
	localparam int FRAC_BITS = 16;
	localparam int SET_W = 4;
	localparam int IDX_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int STR_W = FRAC_BITS + 1;
	localparam int DIV_W = 34 + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_W + 1);

	localparam logic OP_EVAL = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [1:0] MK_TRI = 2'd0;
	localparam logic [1:0] MK_LSH = 2'd1;
	localparam logic [1:0] MK_RSH = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [3:0]  set_a;
		logic [3:0]  set_b;
		logic [3:0]  set_out;
		logic        twin;
		logic [31:0] left_corner;
		logic [31:0] top_corner;
		logic [31:0] right_corner;
		logic [1:0]  member_kind;
		logic        weight_kind;
	} in_item_t;

	typedef struct packed {
		logic [16:0] strength;
		logic [31:0] weight;
		logic [31:0] station;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] left;
		logic signed [31:0] top;
		logic signed [31:0] right;
		logic [2:0]         kinds;
	} set_entry_t;

endpackage

// File: src/fuzzy_rule_evaluator.sv
// load: written to the set table on acceptance; evaluate: each antecedent set is read and its
// membership decided; a ratio then runs the bit-serial divider until its done strobe
// a membership with no division (flat part, outside the set or vertical edge) skips the divider
// a two-antecedent rule repeats this for value_b; the next item is accepted once the output set is read,
// the weight formed and the result registered; one item at a time; a stalled result holds the finished item
// in its last state; reset clears control state only; the set table holds no value until loaded
module fuzzy_rule_evaluator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fre_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fre_pkg::out_item_t  out_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDA   = 4'd1;
	localparam logic [3:0] ST_FUZ   = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_RDB   = 4'd4;
	localparam logic [3:0] ST_RDO   = 4'd5;
	localparam logic [3:0] ST_OUT1  = 4'd6;
	localparam logic [3:0] ST_OUT2  = 4'd7;
	localparam logic [3:0] ST_OUT3  = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	localparam logic [fre_pkg::STR_W-1:0] ONE = fre_pkg::STR_W'(1 << fre_pkg::FRAC_BITS);

	// set table memory
	fre_pkg::set_entry_t mem [fre_pkg::SET_COUNT];
	fre_pkg::set_entry_t rd_q;
	logic                rd_en;
	logic [3:0]          rd_idx;
	logic                rd_oob_q;

	logic [3:0]           state_q;
	fre_pkg::in_item_t    item_q;
	logic                 second_q;    // fuzzifying value_b
	logic [fre_pkg::STR_W-1:0] str_q;
	logic signed [31:0]   x_q;
	logic signed [33:0]   wd_q;        // width for weight
	logic [fre_pkg::STR_W+1:0] g_q;
	logic [66:0]          prod_q;
	logic                 neg_q;
	logic                 lin_q;
	logic signed [31:0]   top_q;
	logic                 out_valid_q;
	fre_pkg::out_item_t   out_q;

	// divider
	logic        div_start;
	logic [33:0] div_num, div_den;
	logic        div_done;
	logic [fre_pkg::STR_W-1:0] div_quo;

	fre_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	wire in_xfer = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (in_xfer && in_data.operation == fre_pkg::OP_LOAD
				&& 32'(in_data.set_a) < 32'(fre_pkg::SET_COUNT)) begin
			mem[in_data.set_a[fre_pkg::IDX_W-1:0]] <= '{in_data.left_corner,
				in_data.top_corner, in_data.right_corner,
				{in_data.weight_kind, in_data.member_kind}};
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx[fre_pkg::IDX_W-1:0]];
		end
	end

	always_comb begin
		rd_en  = 1'b0;
		rd_idx = item_q.set_a;
		case (state_q)
			ST_RDA: rd_en = 1'b1;
			ST_RDB: begin rd_en = 1'b1; rd_idx = item_q.set_b; end
			ST_RDO: begin rd_en = 1'b1; rd_idx = item_q.set_out; end
			default: rd_en = 1'b0;
		endcase
	end

	// membership decision on read entry (out-of-range set reads as zeros)
	logic signed [31:0] ml, mt, mr;
	logic [1:0]         mk;
	logic               fz_imm;
	logic [fre_pkg::STR_W-1:0] fz_val;
	logic signed [33:0] n_s, d_s;

	always_comb begin
		ml = rd_oob_q ? 32'sd0 : rd_q.left;
		mt = rd_oob_q ? 32'sd0 : rd_q.top;
		mr = rd_oob_q ? 32'sd0 : rd_q.right;
		mk = rd_oob_q ? fre_pkg::MK_TRI : rd_q.kinds[1:0];
		fz_imm = 1'b1;
		fz_val = '0;
		n_s = '0;
		d_s = '0;
		if (mk == fre_pkg::MK_LSH) begin
			if (x_q >= mt && x_q <= mr) begin
				fz_imm = 1'b0; n_s = 34'(mr) - 34'(x_q); d_s = 34'(mr) - 34'(mt);
			end else if (x_q < mt) begin
				fz_val = ONE;
			end
		end else if (mk == fre_pkg::MK_RSH) begin
			if (x_q >= ml && x_q <= mt) begin
				fz_imm = 1'b0; n_s = 34'(x_q) - 34'(ml); d_s = 34'(mt) - 34'(ml);
			end else if (x_q > mt) begin
				fz_val = ONE;
			end
		end else begin
			if (x_q >= ml && x_q < mt) begin
				fz_imm = 1'b0; n_s = 34'(x_q) - 34'(ml); d_s = 34'(mt) - 34'(ml);
			end else if (x_q >= mt && x_q <= mr) begin
				fz_imm = 1'b0; n_s = 34'(mr) - 34'(x_q); d_s = 34'(mr) - 34'(mt);
			end
		end
		// zero-width slope gives full strength
		if (!fz_imm && d_s <= 0) begin
			fz_imm = 1'b1;
			fz_val = ONE;
		end
	end

	assign div_start = (state_q == ST_FUZ) && !fz_imm;
	assign div_num   = n_s;
	assign div_den   = d_s;

	// strength result merges with minimum on the second antecedent
	logic [fre_pkg::STR_W-1:0] fz_res;
	logic                      fz_fin;
	always_comb begin
		fz_fin = 1'b0;
		fz_res = fz_val;
		if (state_q == ST_FUZ && fz_imm) fz_fin = 1'b1;
		if (state_q == ST_DIV && div_done) begin
			fz_fin = 1'b1;
			fz_res = div_quo;
		end
	end

	// saturate to 32 bit signed
	logic signed [67:0] wsigned;
	logic signed [31:0] wsat;
	always_comb begin
		wsigned = neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
		if (wsigned > 68'sh7FFFFFFF) wsat = 32'sh7FFFFFFF;
		else if (wsigned < -68'sh80000000) wsat = 32'sh80000000;
		else wsat = wsigned[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_xfer && in_data.operation == fre_pkg::OP_EVAL) state_q <= ST_RDA;
				ST_RDA:  state_q <= ST_FUZ;
				ST_FUZ:  if (fz_imm) state_q <= (!second_q && item_q.twin) ? ST_RDB : ST_RDO;
					else state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= (!second_q && item_q.twin) ? ST_RDB : ST_RDO;
				ST_RDB:  state_q <= ST_FUZ;
				ST_RDO:  state_q <= ST_OUT1;
				ST_OUT1: state_q <= ST_OUT2;
				ST_OUT2: state_q <= ST_OUT3;
				ST_OUT3: state_q <= ST_DONE;
				ST_DONE: if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// width of the output set for the weight
	logic signed [33:0] wdiff;
	always_comb begin
		if (!rd_oob_q && rd_q.kinds[2]) wdiff = 34'(rd_q.top) - 34'(rd_q.left);
		else wdiff = rd_oob_q ? 34'sd0 : 34'(rd_q.right) - 34'(rd_q.left);
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_xfer) begin
				item_q   <= in_data;
				x_q      <= in_data.value_a;
				second_q <= 1'b0;
				rd_oob_q <= 32'(in_data.set_a) >= 32'(fre_pkg::SET_COUNT);
			end
			ST_FUZ, ST_DIV: if (fz_fin) begin
				if (!second_q || fz_res < str_q) str_q <= fz_res;
				if (!second_q && item_q.twin) begin
					second_q <= 1'b1;
					x_q      <= item_q.value_b;
					rd_oob_q <= 32'(item_q.set_b) >= 32'(fre_pkg::SET_COUNT);
				end else begin
					rd_oob_q <= 32'(item_q.set_out) >= 32'(fre_pkg::SET_COUNT);
				end
			end
			ST_OUT1: begin
				lin_q <= rd_oob_q ? 1'b0 : rd_q.kinds[2];
				top_q <= rd_oob_q ? 32'sd0 : rd_q.top;
				if (!rd_oob_q && rd_q.kinds[2]) begin
					g_q <= (fre_pkg::STR_W+2)'(str_q);
				end else begin
					// area factor g = (2*ONE - s) * s / ONE, formed in next step
					g_q <= '0;
				end
				wd_q  <= wdiff;
				neg_q <= wdiff < 0;
			end
			ST_OUT2: begin
				if (!lin_q) begin
					g_q <= (fre_pkg::STR_W+2)'(((64'(ONE) * 2 - 64'(str_q)) * 64'(str_q))
						>> fre_pkg::FRAC_BITS);
				end
				wd_q <= wd_q < 0 ? -wd_q : wd_q;
			end
			ST_OUT3: begin
				prod_q <= (67'(wd_q) * 67'(g_q)) >> (lin_q ? fre_pkg::FRAC_BITS
					: fre_pkg::FRAC_BITS + 1);
			end
			ST_DONE: if (!out_valid_q || !out_stall) begin
				out_q.strength <= 17'(str_q);
				out_q.weight   <= wsat;
				out_q.station  <= lin_q ? wsat : top_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("busy but accepting");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("result lost under stall");
	a_div_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV)) else $error("stray divider done");

endmodule

// File: src/fre_divider.sv
// restoring divider: quo = min(floor(num * ONE / den), ONE), one bit a cycle
module fre_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [33:0]                   num,
	input  logic [33:0]                   den,
	output logic                          done,
	output logic [fre_pkg::STR_W-1:0]     quo
);

	logic [fre_pkg::DIV_W-1:0] dvd_q;
	logic [fre_pkg::DIV_W-1:0] quo_q;
	logic [34:0]               rem_q;
	logic [33:0]               den_q;
	logic [fre_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic [34:0]               trial;
	logic [35:0]               diff;

	assign trial = {rem_q[33:0], dvd_q[fre_pkg::DIV_W-1]};
	assign diff  = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == fre_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, {fre_pkg::FRAC_BITS{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= fre_pkg::CNT_W'(fre_pkg::DIV_W);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[fre_pkg::DIV_W-2:0], 1'b0};
			cnt_q <= cnt_q - fre_pkg::CNT_W'(1);
			if (!diff[35]) begin
				rem_q <= diff[34:0];
				quo_q <= {quo_q[fre_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[fre_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quo = (quo_q > fre_pkg::DIV_W'(1 << fre_pkg::FRAC_BITS))
		? fre_pkg::STR_W'(1 << fre_pkg::FRAC_BITS) : quo_q[fre_pkg::STR_W-1:0];

endmodule
